/* hdl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked assertion that also checks through reset.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hdl/mlhc_pkg.sv */
// Package for the multi-level hysteresis comparator: types, widths and codes.
`default_nettype none
package mlhc_pkg;

  localparam int LEVEL_BITS    = 3;
  localparam int SAMPLE_BITS   = 16;
  localparam int BOUND_BITS    = 16;
  localparam int ZONE_REGS     = 4;
  localparam int ZONE_IDX_BITS = 2;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 32;

  localparam logic [LEVEL_BITS-1:0] MAX_ZONES = 3'd4;
  localparam logic [BOUND_BITS-1:0] BOUND_MAX = '1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] REG_ZONE_COUNT = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_ZONE0      = 3'd1;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_CLEAR  = 1'b1
  } mlhc_op_t;

  typedef struct packed {
    mlhc_op_t                 operation;
    logic [SAMPLE_BITS-1:0]   sample;
  } mlhc_in_t;

  typedef struct packed {
    logic [LEVEL_BITS-1:0] level;
    logic                  changed_flag;
  } mlhc_out_t;

  // Zone set-up with bounds already ordered.
  typedef struct packed {
    logic [LEVEL_BITS-1:0]                 count;
    logic [ZONE_REGS-1:0][BOUND_BITS-1:0]  lower;
    logic [ZONE_REGS-1:0][BOUND_BITS-1:0]  upper;
  } mlhc_zone_cfg_t;

endpackage
`default_nettype wire

/* hdl/mlhc_zone_regs.sv */
// Configuration registers: clamped zone count and ordered deadzone bounds.
`default_nettype none
module mlhc_zone_regs (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [mlhc_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [mlhc_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  output mlhc_pkg::mlhc_zone_cfg_t             zones
);
  import mlhc_pkg::*;

  logic [BOUND_BITS-1:0] bound_a;
  logic [BOUND_BITS-1:0] bound_b;
  logic                  a_smaller;

  assign bound_a   = cfg_data[BOUND_BITS-1:0];
  assign bound_b   = cfg_data[2*BOUND_BITS-1:BOUND_BITS];
  assign a_smaller = bound_a < bound_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      zones <= '0;
    end else if (cfg_write) begin
      if (cfg_index == REG_ZONE_COUNT) begin
        zones.count <= (cfg_data[LEVEL_BITS-1:0] > MAX_ZONES) ? MAX_ZONES
                                                              : cfg_data[LEVEL_BITS-1:0];
      end
      // Order the two bounds on write so the datapath sees lower <= upper.
      for (int k = 0; k < ZONE_REGS; k++) begin
        if (cfg_index == CFG_IDX_BITS'(REG_ZONE0 + CFG_IDX_BITS'(k))) begin
          zones.lower[k] <= a_smaller ? bound_a : bound_b;
          zones.upper[k] <= a_smaller ? bound_b : bound_a;
        end
      end
    end
  end

endmodule
`default_nettype wire

/* hdl/mlhc_level_unit.sv */
// Level state and one-step hysteresis decision for a registered item.
`default_nettype none
module mlhc_level_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      step,
  input  mlhc_pkg::mlhc_in_t        item,
  input  mlhc_pkg::mlhc_zone_cfg_t  zones,
  output mlhc_pkg::mlhc_out_t       result
);
  import mlhc_pkg::*;

  logic [LEVEL_BITS-1:0]    current_level;
  logic [LEVEL_BITS-1:0]    level_next;
  logic                     level_changed;
  logic                     changed_next;
  logic [ZONE_IDX_BITS-1:0] below_idx;
  logic [BOUND_BITS-1:0]    lower_th;
  logic [BOUND_BITS-1:0]    upper_th;

  always_comb begin
    below_idx = ZONE_IDX_BITS'(current_level - LEVEL_BITS'(1));
    // Floor at level zero, ceiling at or above the zone count.
    lower_th  = (current_level != '0) ? zones.lower[below_idx] : '0;
    upper_th  = (current_level < zones.count)
                ? zones.upper[current_level[ZONE_IDX_BITS-1:0]] : BOUND_MAX;
    level_next   = current_level;
    changed_next = level_changed;
    unique case (item.operation)
      OP_CLEAR: begin
        changed_next = 1'b0;
      end
      OP_SAMPLE: begin
        if (item.sample < lower_th) begin
          level_next   = current_level - LEVEL_BITS'(1);
          changed_next = 1'b1;
        end else if (item.sample > upper_th) begin
          level_next   = current_level + LEVEL_BITS'(1);
          changed_next = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_level <= '0;
      level_changed <= 1'b0;
    end else if (step) begin
      current_level <= level_next;
      level_changed <= changed_next;
    end
  end

  assign result.level        = level_next;
  assign result.changed_flag = changed_next;

endmodule
`default_nettype wire

/* hdl/multi_level_hysteresis_comparator.sv */
// Top level of the multi-level hysteresis comparator.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    in_item  (operation, sample)
//   out      output     out_valid / out_ready  out_item (level, changed_flag)
//   cfg      input      cfg_write              cfg_index, cfg_data
//
// One transaction per cycle sustained while the output is not stalled; each one passes
// through the input register and then the result register.
// The level decision (two 16-bit compares and a step) sits between the two registers.
// rst is synchronous: both stages empty, level and changed flag zero, config registers zero.
// A stalled output holds its result; the input register still fills behind it.
`default_nettype none
module multi_level_hysteresis_comparator (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  mlhc_pkg::mlhc_in_t                  in_item,
  output logic                                out_valid,
  input  logic                                out_ready,
  output mlhc_pkg::mlhc_out_t                 out_item,
  input  logic                                cfg_write,
  input  logic [mlhc_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [mlhc_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import mlhc_pkg::*;

  logic           stage_valid;
  mlhc_in_t       stage_item;
  logic           advance;
  mlhc_zone_cfg_t zones;
  mlhc_out_t      result;

  assign advance  = stage_valid && (!out_valid || out_ready);
  assign in_ready = !stage_valid || advance;

  mlhc_zone_regs u_zone_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .zones     (zones)
  );

  mlhc_level_unit u_level_unit (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (stage_item),
    .zones  (zones),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage_item <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= result;
    end
  end

endmodule
`default_nettype wire

/* hdl/mlhc_checker.sv */
// Port-level checker for the comparator, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module mlhc_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input mlhc_pkg::mlhc_out_t  out_item
);
  import mlhc_pkg::*;

  logic                  prev_seen;
  logic [LEVEL_BITS-1:0] prev_level;

  // Track the level of the last delivered result.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_seen <= 1'b0;
    end else if (out_valid && out_ready) begin
      prev_seen <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && out_ready) begin
      prev_level <= out_item.level;
    end
  end

  `ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_item), "result dropped or changed while stalled")
  `ASSERT_CLK(a_level_range, out_valid |-> out_item.level <= MAX_ZONES, "level above zone limit")
  `ASSERT_CLK(a_level_step, out_valid && prev_seen |-> out_item.level == prev_level || out_item.level == LEVEL_BITS'(prev_level + LEVEL_BITS'(1)) || prev_level == LEVEL_BITS'(out_item.level + LEVEL_BITS'(1)), "level moved by more than one")
  `ASSERT_CLK(a_change_flag, out_valid && prev_seen && out_item.level != prev_level |-> out_item.changed_flag, "level changed without flag")
  `ASSERT_CLK_ALWAYS(a_reset_empty, $past(rst) |-> !out_valid && in_ready, "block not empty after reset")

endmodule

bind multi_level_hysteresis_comparator mlhc_checker u_mlhc_checker (.*);
`default_nettype wire
